// File: rtl/lstm_cell_hard_activation_unit_macros.svh
// Assertion macros for the LSTM cell block.
`ifndef LSTM_CELL_HARD_ACTIVATION_UNIT_MACROS_SVH
`define LSTM_CELL_HARD_ACTIVATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock once out of reset
`define LCHAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lchau assertion failed");
// condition must never be true
`define LCHAU_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lchau forbidden condition seen");
`else
`define LCHAU_ASSERT(lbl, prop)
`define LCHAU_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: rtl/lchau_pkg.sv
package lchau_pkg;

  // default sizing
  localparam int MAX_UNITS_DEF     = 64;
  localparam int MAX_INPUTS_DEF    = 64;
  localparam int DATA_WIDTH_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 12;

  // index field width covers the largest supported unit/input count
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;
  localparam int REG_RESET = 32;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    GATE_INPUT  = 2'd0,
    GATE_OUTPUT = 2'd1,
    GATE_FORGET = 2'd2,
    GATE_CAND   = 2'd3
  } gate_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUTS = 2'd0,
    CFG_UNITS  = 2'd1
  } cfg_idx_e;

  // input word
  typedef struct packed {
    op_e               op;
    gate_e             gate_select;
    logic              is_recurrent;
    logic [5:0]        row_index;
    logic [5:0]        col_index;
    logic signed [15:0] value;
    logic              last_element;
  } in_t;

  // result word
  typedef struct packed {
    logic [5:0]         unit_number;
    logic signed [15:0] hidden_value;
    logic               last_unit;
  } out_t;

  // token that walks the cell chain, one per multiply-accumulate
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             rec;
    logic [IDX_W-1:0] unit;
    logic [IDX_W-1:0] col;
  } tok_t;

  // memory write request to the cells
  typedef struct packed {
    logic             w_en;
    logic             b_en;
    logic             rec;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } wr_t;

  // finished gate value from a cell
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
  } gres_t;

  // saturate to a signed dw-bit range
  function automatic logic signed [63:0] sat_to(input logic signed [63:0] v, input int dw);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (dw - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // fixed-point product rescale: floor shift, then saturate
  function automatic logic signed [63:0] mul_shift(input logic signed [63:0] p,
                                                  input int fb, input int dw);
    return sat_to(p >>> fb, dw);
  endfunction

  function automatic logic signed [63:0] hard_sigmoid(input logic signed [63:0] x,
                                                     input int fb, input int dw);
    logic signed [63:0] one;
    logic signed [63:0] y;
    one = 64'sd1 <<< fb;
    y = x + (64'sd1 <<< (fb - 1));
    if (y < 64'sd0) y = 64'sd0;
    if (y > one) y = one;
    return sat_to(y, dw);
  endfunction

  function automatic logic signed [63:0] hard_tanh(input logic signed [63:0] x,
                                                  input int fb, input int dw);
    logic signed [63:0] one;
    logic signed [63:0] y;
    one = 64'sd1 <<< fb;
    y = x;
    if (y > one) y = one;
    if (y < -one) y = -one;
    return sat_to(y, dw);
  endfunction

endpackage

// File: rtl/lchau_ram.sv
module lchau_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// File: rtl/lchau_cell.sv
module lchau_cell #(
  parameter int MaxUnits     = 64,
  parameter int MaxInputs    = 64,
  parameter int DataWidth    = 16,
  parameter int FractionBits = 12,
  parameter bit IsTanh       = 1'b0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lchau_pkg::wr_t              wr_i,
  input  logic signed [DataWidth-1:0] wdata_i,
  input  lchau_pkg::tok_t             tok_i,
  input  logic signed [DataWidth-1:0] elem_i,
  output lchau_pkg::tok_t             tok_o,
  output logic signed [DataWidth-1:0] elem_o,
  output lchau_pkg::gres_t            gate_o
);
  import lchau_pkg::*;

  localparam int UIW = (MaxUnits > 1) ? $clog2(MaxUnits) : 1;
  localparam int MaxCols = (MaxInputs > MaxUnits) ? MaxInputs : MaxUnits;
  localparam int CW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int WDepth = MaxUnits * 2 * (1 << CW);
  localparam int WAW = UIW + 1 + CW;

  logic [DataWidth-1:0] w_rd, b_rd;
  tok_t s1_q, c2_q;
  logic signed [DataWidth-1:0] elem_q, b2_q, acc_q;
  logic signed [2*DataWidth-1:0] prod_q;
  gres_t gate_q;

  // weight memory: {unit, recurrent, column}
  lchau_ram #(.Width(DataWidth), .Depth(WDepth)) u_wram (
    .clk_i  (clk_i),
    .we_i   (wr_i.w_en),
    .waddr_i(WAW'({wr_i.row[UIW-1:0], wr_i.rec, wr_i.col[CW-1:0]})),
    .wdata_i(wdata_i),
    .re_i   (tok_i.valid),
    .raddr_i(WAW'({tok_i.unit[UIW-1:0], tok_i.rec, tok_i.col[CW-1:0]})),
    .rdata_o(w_rd)
  );

  // bias memory, one entry per unit
  lchau_ram #(.Width(DataWidth), .Depth(MaxUnits)) u_bram (
    .clk_i  (clk_i),
    .we_i   (wr_i.b_en),
    .waddr_i(wr_i.row[UIW-1:0]),
    .wdata_i(wdata_i),
    .re_i   (tok_i.valid & tok_i.first),
    .raddr_i(tok_i.unit[UIW-1:0]),
    .rdata_o(b_rd)
  );

  // accumulate stage
  logic signed [DataWidth-1:0] term, base, acc_d;
  always_comb begin
    term  = DataWidth'(mul_shift(64'(prod_q), FractionBits, DataWidth));
    base  = c2_q.first ? b2_q : acc_q;
    acc_d = DataWidth'(sat_to(64'(base) + 64'(term), DataWidth));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      c2_q   <= '0;
      gate_q <= '0;
    end else begin
      s1_q         <= tok_i;
      c2_q         <= s1_q;
      gate_q.valid <= c2_q.valid & c2_q.last;
      if (c2_q.valid & c2_q.last) begin
        gate_q.value <= IsTanh ? 32'(hard_tanh(64'(acc_d), FractionBits, DataWidth))
                               : 32'(hard_sigmoid(64'(acc_d), FractionBits, DataWidth));
      end
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    elem_q <= elem_i;
    prod_q <= $signed(w_rd) * elem_i;
    b2_q   <= $signed(b_rd);
    if (c2_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign tok_o  = s1_q;
  assign elem_o = elem_q;
  assign gate_o = gate_q;
endmodule

// File: rtl/lstm_cell_hard_activation_unit.sv
// LSTM cell, fixed point with hard activations. Weight, bias and clear words
// are taken while idle. An input element marked last starts a step: units are
// worked one after another, each one streaming its ni input plus nu recurrent
// terms through a chain of four gate cells (one multiply-accumulate per cell per
// cycle), then waiting for the chain to drain, then updating cell and hidden
// state in the states MUL, SUM, HMUL and EMIT. Output stalls hold the step in
// EMIT; no word is accepted meanwhile.
// Hidden values leave through an output register, one word per unit in order.
module lstm_cell_hard_activation_unit #(
  parameter int MaxUnits     = lchau_pkg::MAX_UNITS_DEF,
  parameter int MaxInputs    = lchau_pkg::MAX_INPUTS_DEF,
  parameter int DataWidth    = lchau_pkg::DATA_WIDTH_DEF,
  parameter int FractionBits = lchau_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lchau_pkg::in_t                      in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lchau_pkg::out_t                     out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lchau_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lchau_pkg::CFG_W-1:0]         cfg_data_i
);
  import lchau_pkg::*;
  `include "lstm_cell_hard_activation_unit_macros.svh"

  localparam int UIW = (MaxUnits > 1) ? $clog2(MaxUnits) : 1;
  localparam int IIW = (MaxInputs > 1) ? $clog2(MaxInputs) : 1;
  localparam int MaxCols = (MaxInputs > MaxUnits) ? MaxInputs : MaxUnits;
  localparam int CW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int NW = $clog2(MaxCols + 1);
  localparam int DW = DataWidth;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ISSUE = 7'b0000010,
    S_WAIT  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_HMUL  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CFG_W-1:0] ni_cfg_q, nu_cfg_q;
  logic [NW-1:0] ni_q, nu_q;
  logic [CW-1:0] j_q;
  logic phase_q;
  logic [UIW-1:0] unit_q;
  logic [MaxUnits-1:0] hsel_q;
  logic [2*MaxUnits-1:0] hv_q;
  logic [MaxUnits-1:0] cv_q;
  logic rec_rd_q, hv_rd_q, cv_rd_q;
  logic signed [DW-1:0] gates_q [4];
  logic signed [2*DW-1:0] m1_q, m2_q, m3_q;
  logic signed [DW-1:0] c_q;
  logic out_valid_q;
  out_t out_q;

  // configuration port
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ni_cfg_q <= CFG_W'(REG_RESET);
      nu_cfg_q <= CFG_W'(REG_RESET);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_INPUTS) ni_cfg_q <= cfg_data_i;
      if (cfg_index_i == CFG_UNITS)  nu_cfg_q <= cfg_data_i;
    end
  end

  // input word decode
  logic in_acc;
  logic signed [DW-1:0] val_dw;
  logic row_ok, colx_ok, colh_ok, step_go;
  wr_t wr [4];
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc = in_valid_i & in_ready_o;
  always_comb begin
    val_dw  = DW'(sat_to(64'(in_word_i.value), DW));
    row_ok  = int'(in_word_i.row_index) < MaxUnits;
    colx_ok = int'(in_word_i.col_index) < MaxInputs;
    colh_ok = int'(in_word_i.col_index) < MaxUnits;
    step_go = in_acc && in_word_i.op == OP_INPUT && in_word_i.last_element;
    for (int g = 0; g < 4; g++) begin
      wr[g].rec  = in_word_i.is_recurrent;
      wr[g].row  = in_word_i.row_index;
      wr[g].col  = in_word_i.col_index;
      wr[g].w_en = in_acc && in_word_i.op == OP_WEIGHT && row_ok &&
                   (in_word_i.is_recurrent ? colh_ok : colx_ok) &&
                   in_word_i.gate_select == gate_e'(g);
      wr[g].b_en = in_acc && in_word_i.op == OP_BIAS && row_ok &&
                   in_word_i.gate_select == gate_e'(g);
    end
  end

  // token for the head of the chain
  tok_t tok [5];
  logic signed [DW-1:0] elem [5];
  gres_t gres [4];
  logic j_last;
  always_comb begin
    j_last = (NW'(j_q) + NW'(1)) == (phase_q ? nu_q : ni_q);
    tok[0].valid = (state_q == S_ISSUE);
    tok[0].first = !phase_q && j_q == '0;
    tok[0].last  = phase_q && j_last;
    tok[0].rec   = phase_q;
    tok[0].unit  = IDX_W'(unit_q);
    tok[0].col   = IDX_W'(j_q);
  end

  // input buffer and hidden state (two banks per unit: old read, new written;
  // a unit's bank select flips at the end of a step that updated it)
  logic [DW-1:0] x_rd, h_rd, c_rd;
  logic h_we;
  logic signed [DW-1:0] h_new, c_new;
  lchau_ram #(.Width(DW), .Depth(MaxInputs)) u_xram (
    .clk_i  (clk_i),
    .we_i   (in_acc && in_word_i.op == OP_INPUT && colx_ok),
    .waddr_i(in_word_i.col_index[IIW-1:0]),
    .wdata_i(val_dw),
    .re_i   (tok[0].valid & !phase_q),
    .raddr_i(j_q[IIW-1:0]),
    .rdata_o(x_rd)
  );
  lchau_ram #(.Width(DW), .Depth(2 * MaxUnits)) u_hram (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i({~hsel_q[unit_q], unit_q}),
    .wdata_i(h_new),
    .re_i   (tok[0].valid & phase_q),
    .raddr_i({hsel_q[j_q[UIW-1:0]], j_q[UIW-1:0]}),
    .rdata_o(h_rd)
  );
  lchau_ram #(.Width(DW), .Depth(MaxUnits)) u_cram (
    .clk_i  (clk_i),
    .we_i   (state_q == S_SUM),
    .waddr_i(unit_q),
    .wdata_i(c_new),
    .re_i   (state_q == S_ISSUE),
    .raddr_i(unit_q),
    .rdata_o(c_rd)
  );

  assign elem[0] = rec_rd_q ? (hv_rd_q ? $signed(h_rd) : '0) : $signed(x_rd);

  // chain of gate cells
  for (genvar g = 0; g < 4; g++) begin : g_cell
    lchau_cell #(
      .MaxUnits    (MaxUnits),
      .MaxInputs   (MaxInputs),
      .DataWidth   (DW),
      .FractionBits(FractionBits),
      .IsTanh      (g == int'(GATE_FORGET))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr[g]),
      .wdata_i(val_dw),
      .tok_i  (tok[g]),
      .elem_i (elem[g]),
      .tok_o  (tok[g+1]),
      .elem_o (elem[g+1]),
      .gate_o (gres[g])
    );
  end

  // update arithmetic
  logic out_free;
  always_comb begin
    c_new = DW'(sat_to(mul_shift(64'(m1_q), FractionBits, DW) +
                       mul_shift(64'(m2_q), FractionBits, DW), DW));
    h_new = DW'(mul_shift(64'(m3_q), FractionBits, DW));
    out_free = !out_valid_q || out_ready_i;
    h_we = (state_q == S_EMIT) && out_free;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (step_go) state_d = S_ISSUE;
      S_ISSUE: if (phase_q && j_last) state_d = S_WAIT;
      S_WAIT:  if (gres[3].valid) state_d = S_MUL;
      S_MUL:   state_d = S_SUM;
      S_SUM:   state_d = S_HMUL;
      S_HMUL:  state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = ((NW'(unit_q) + NW'(1)) == nu_q) ? S_IDLE : S_ISSUE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ni_q        <= '0;
      nu_q        <= '0;
      j_q         <= '0;
      phase_q     <= 1'b0;
      unit_q      <= '0;
      hsel_q      <= '0;
      hv_q        <= '0;
      cv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (h_we) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (in_acc && in_word_i.op == OP_CLEAR) begin
        hv_q <= '0;
        cv_q <= '0;
      end
      if (step_go) begin
        ni_q    <= (ni_cfg_q == '0) ? NW'(1) :
                   (int'(ni_cfg_q) > MaxInputs) ? NW'(MaxInputs) : NW'(ni_cfg_q);
        nu_q    <= (nu_cfg_q == '0) ? NW'(1) :
                   (int'(nu_cfg_q) > MaxUnits) ? NW'(MaxUnits) : NW'(nu_cfg_q);
        unit_q  <= '0;
        j_q     <= '0;
        phase_q <= 1'b0;
      end
      if (state_q == S_ISSUE) begin
        if (j_last) begin
          j_q     <= '0;
          phase_q <= ~phase_q;
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
      if (state_q == S_SUM) cv_q[unit_q] <= 1'b1;
      if (h_we) begin
        hv_q[{~hsel_q[unit_q], unit_q}] <= 1'b1;
        if ((NW'(unit_q) + NW'(1)) == nu_q) begin
          // every unit of this step now reads its new bank
          for (int u = 0; u < MaxUnits; u++) begin
            if (NW'(u) < nu_q) hsel_q[u] <= ~hsel_q[u];
          end
        end else begin
          unit_q <= unit_q + UIW'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rec_rd_q <= phase_q;
    hv_rd_q  <= hv_q[{hsel_q[j_q[UIW-1:0]], j_q[UIW-1:0]}];
    if (state_q == S_ISSUE) cv_rd_q <= cv_q[unit_q];
    for (int g = 0; g < 4; g++) begin
      if (gres[g].valid) gates_q[g] <= DW'(gres[g].value);
    end
    if (state_q == S_MUL) begin
      m1_q <= gates_q[GATE_FORGET] * (cv_rd_q ? $signed(c_rd) : DW'(0));
      m2_q <= gates_q[GATE_INPUT] * gates_q[GATE_CAND];
    end
    if (state_q == S_SUM) c_q <= c_new;
    if (state_q == S_HMUL) begin
      m3_q <= gates_q[GATE_OUTPUT] * DW'(hard_tanh(64'(c_q), FractionBits, DW));
    end
    if (h_we) begin
      out_q.unit_number  <= 6'(unit_q);
      out_q.hidden_value <= 16'(h_new);
      out_q.last_unit    <= (NW'(unit_q) + NW'(1)) == nu_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // checks
  `LCHAU_ASSERT(a_onehot_state, $onehot(state_q))
  `LCHAU_ASSERT(a_gate_in_wait, gres[3].valid |-> state_q == S_WAIT)
  `LCHAU_ASSERT(a_last_to_idle, (h_we && out_q.last_unit == 1'b0 &&
      (NW'(unit_q) + NW'(1)) == nu_q) |=> state_q == S_IDLE)
  `LCHAU_ASSERT_NEVER(a_unit_range, state_q == S_ISSUE && NW'(unit_q) >= nu_q)
endmodule
